// ===== sv/osc7_pkg.sv =====
// ----------------------------------------------------------------------------
// osc7_pkg
// Shared types and constants for the OSC 7 working directory extractor.
// ----------------------------------------------------------------------------
package osc7_pkg;

    localparam int BODY_DEPTH_DEF = 64;
    localparam int JQ_DEPTH       = 2;
    localparam int OQ_DEPTH       = 4;
    localparam int OQ_CW          = $clog2(OQ_DEPTH + 1);

    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_BEL   = 8'h07;
    localparam logic [7:0] BYTE_OSC   = 8'h5D;
    localparam logic [7:0] BYTE_BSL   = 8'h5C;
    localparam logic [7:0] BYTE_SEVEN = 8'h37;
    localparam logic [7:0] BYTE_SEMI  = 8'h3B;

    localparam logic [1:0] ST_PATH  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    typedef enum logic [1:0] {
        KIND_OVF,
        KIND_EMPTY,
        KIND_PATH
    } t_kind;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       run_last;
        logic [1:0] report_status;
    } t_result;

endpackage

// ===== sv/osc7_ram.sv =====
// ----------------------------------------------------------------------------
// osc7_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module osc7_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/osc7_fifo.sv =====
// ----------------------------------------------------------------------------
// osc7_fifo
// Small synchronous FIFO with occupancy count.
// ----------------------------------------------------------------------------
module osc7_fifo #(
    parameter int W = 8,
    parameter int D = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  logic [W-1:0]           i_din,
    input  logic                   i_rd,
    output logic [W-1:0]           o_dout,
    output logic                   o_empty,
    output logic                   o_full,
    output logic [$clog2(D+1)-1:0] o_count
);
    localparam int AW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);

    logic [W-1:0]  r_mem [D];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_wr, w_rd;

    assign w_wr = i_wr && (r_cnt != CW'(D));
    assign w_rd = i_rd && (r_cnt != '0);

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == AW'(D - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_rd) begin
            n_rp = (r_rp == AW'(D - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_din;
        end
    end

    assign o_dout  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(D));
    assign o_count = r_cnt;
endmodule

// ===== sv/osc7_front.sv =====
// ----------------------------------------------------------------------------
// osc7_front
// Byte scanner: tracks escape phase, stores body bytes, posts report jobs.
// ----------------------------------------------------------------------------
module osc7_front #(
    parameter int BODY_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic [7:0]                      i_byte,
    output logic                            o_job_push,
    output osc7_pkg::t_kind                 o_job_kind,
    output logic [$clog2(BODY_DEPTH+1)-1:0] o_job_count,
    input  logic                            i_jq_full,
    input  logic                            i_done,
    output logic                            o_ram_we,
    output logic [$clog2(BODY_DEPTH)-1:0]   o_ram_waddr,
    output logic [7:0]                      o_ram_wdata
);
    import osc7_pkg::*;

    localparam int CW = $clog2(BODY_DEPTH + 1);
    localparam int AW = $clog2(BODY_DEPTH);

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_ESC      = 2'd1;
    localparam logic [1:0] PH_BODY     = 2'd2;
    localparam logic [1:0] PH_BODY_ESC = 2'd3;

    logic [1:0]    r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic          r_p0, n_p0;
    logic          r_pok, n_pok;
    logic          r_lock, n_lock;
    logic          w_acc;
    logic          w_fin;

    assign o_full = r_lock || i_jq_full;
    assign w_acc  = i_push && !o_full;

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_p0        = r_p0;
        n_pok       = r_pok;
        n_lock      = r_lock && !i_done;
        w_fin       = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_cnt[AW-1:0];
        o_ram_wdata = i_byte;
        o_job_push  = 1'b0;
        o_job_kind  = KIND_PATH;
        o_job_count = r_cnt;
        if (w_acc) begin
            case (r_phase)
                PH_IDLE: begin
                    n_phase = (i_byte == BYTE_ESC) ? PH_ESC : PH_IDLE;
                end
                PH_ESC: begin
                    if (i_byte == BYTE_OSC) begin
                        n_phase = PH_BODY;
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_p0    = 1'b0;
                        n_pok   = 1'b0;
                    end else begin
                        n_phase = (i_byte == BYTE_ESC) ? PH_ESC : PH_IDLE;
                    end
                end
                PH_BODY: begin
                    if (i_byte == BYTE_BEL) begin
                        w_fin = 1'b1;
                    end else if (i_byte == BYTE_ESC) begin
                        n_phase = PH_BODY_ESC;
                    end else if (r_cnt < CW'(BODY_DEPTH)) begin
                        o_ram_we = 1'b1;
                        n_cnt    = r_cnt + 1'b1;
                        if (r_cnt == CW'(0)) begin
                            n_p0 = (i_byte == BYTE_SEVEN);
                        end
                        if (r_cnt == CW'(1)) begin
                            n_pok = r_p0 && (i_byte == BYTE_SEMI);
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                PH_BODY_ESC: begin
                    if (i_byte == BYTE_BSL) begin
                        w_fin = 1'b1;
                    end else begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_pok   = 1'b0;
                        n_phase = (i_byte == BYTE_ESC) ? PH_ESC : PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
        if (w_fin) begin
            if (r_ovf) begin
                o_job_push = 1'b1;
                o_job_kind = KIND_OVF;
            end else if (r_pok) begin
                o_job_push = 1'b1;
                if (r_cnt == CW'(2)) begin
                    o_job_kind = KIND_EMPTY;
                end else begin
                    o_job_kind = KIND_PATH;
                    n_lock     = 1'b1;
                end
            end
            n_phase = PH_IDLE;
            n_cnt   = '0;
            n_ovf   = 1'b0;
            n_pok   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_p0    <= 1'b0;
            r_pok   <= 1'b0;
            r_lock  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_p0    <= n_p0;
            r_pok   <= n_pok;
            r_lock  <= n_lock;
        end
    end
endmodule

// ===== sv/osc7_back.sv =====
// ----------------------------------------------------------------------------
// osc7_back
// Report engine: turns jobs into results, streaming path bytes from the store.
// ----------------------------------------------------------------------------
module osc7_back #(
    parameter int BODY_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_job_valid,
    input  osc7_pkg::t_kind                 i_job_kind,
    input  logic [$clog2(BODY_DEPTH+1)-1:0] i_job_count,
    output logic                            o_job_pop,
    output logic                            o_done,
    output logic                            o_ram_re,
    output logic [$clog2(BODY_DEPTH)-1:0]   o_ram_raddr,
    input  logic [7:0]                      i_ram_rdata,
    output logic                            o_res_push,
    output osc7_pkg::t_result               o_res,
    input  logic [osc7_pkg::OQ_CW-1:0]      i_oq_count
);
    import osc7_pkg::*;

    localparam int CW = $clog2(BODY_DEPTH + 1);
    localparam int AW = $clog2(BODY_DEPTH);

    logic          r_busy, n_busy;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_end, n_end;
    logic          r_pend, n_pend;
    logic          r_pend_last, n_pend_last;
    logic          w_credit;
    logic [CW-1:0] w_last_idx;

    assign w_credit   = r_pend ? (i_oq_count < OQ_CW'(OQ_DEPTH - 1))
                               : (i_oq_count < OQ_CW'(OQ_DEPTH));
    assign w_last_idx = i_job_count - 1'b1;

    always_comb begin
        n_busy      = r_busy;
        n_addr      = r_addr;
        n_end       = r_end;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        o_job_pop   = 1'b0;
        o_done      = 1'b0;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_addr;
        o_res_push  = 1'b0;
        o_res       = '{path_byte: i_ram_rdata, run_last: r_pend_last,
                        report_status: ST_PATH};
        if (r_pend) begin
            o_res_push = 1'b1;
        end
        if (r_busy) begin
            if (w_credit) begin
                o_ram_re    = 1'b1;
                n_pend      = 1'b1;
                n_pend_last = (r_addr == r_end);
                if (r_addr == r_end) begin
                    n_busy = 1'b0;
                    o_done = 1'b1;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
        end else if (i_job_valid && !r_pend && w_credit) begin
            o_job_pop = 1'b1;
            case (i_job_kind)
                KIND_OVF: begin
                    o_res_push = 1'b1;
                    o_res      = '{path_byte: 8'd0, run_last: 1'b1,
                                   report_status: ST_OVF};
                end
                KIND_EMPTY: begin
                    o_res_push = 1'b1;
                    o_res      = '{path_byte: 8'd0, run_last: 1'b1,
                                   report_status: ST_EMPTY};
                end
                KIND_PATH: begin
                    n_busy = 1'b1;
                    n_addr = AW'(2);
                    n_end  = w_last_idx[AW-1:0];
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_end       <= n_end;
        r_pend_last <= n_pend_last;
    end
endmodule

// ===== sv/osc7_working_dir_extractor_core.sv =====
// ----------------------------------------------------------------------------
// osc7_working_dir_extractor_core
// OSC 7 working directory extractor: scanner front, job queue, report back.
// ----------------------------------------------------------------------------
// Input: one byte per cycle while no path report is being streamed and the
// job queue has room. Overflow and empty-path results pass the job queue and
// the result queue; a path byte also passes the read address and store read
// registers. Path report of n body bytes: n-2 results at one per cycle while
// the result queue has room; input is held off (full) from the terminator
// until the last store read is issued. Overflow and empty-path reports need
// no store access; they stall input only once the job queue is full. Reset:
// synchronous, active low; clears control state, store left as is.
// ----------------------------------------------------------------------------
module osc7_working_dir_extractor_core #(
    parameter int BODY_DEPTH = osc7_pkg::BODY_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_path_byte,
    output logic       o_run_last,
    output logic [1:0] o_report_status
);
    import osc7_pkg::*;

    localparam int CW = $clog2(BODY_DEPTH + 1);
    localparam int AW = $clog2(BODY_DEPTH);
    localparam int JW = $bits(t_kind) + CW;
    localparam int RW = $bits(t_result);

    logic          w_job_push;
    t_kind         w_job_kind;
    logic [CW-1:0] w_job_count;
    logic          w_jq_full;
    logic          w_jq_empty;
    logic [JW-1:0] w_jq_dout;
    logic [$clog2(JQ_DEPTH+1)-1:0] w_jq_count;
    logic          w_job_pop;
    logic          w_done;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [7:0]    w_ram_wdata;
    logic          w_ram_re;
    logic [AW-1:0] w_ram_raddr;
    logic [7:0]    w_ram_rdata;
    logic          w_res_push;
    t_result       w_res;
    t_result       w_oq_dout;
    logic          w_oq_full;
    logic [OQ_CW-1:0] w_oq_count;
    logic          w_unused;

    osc7_front #(.BODY_DEPTH(BODY_DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_byte      (i_in_byte),
        .o_job_push  (w_job_push),
        .o_job_kind  (w_job_kind),
        .o_job_count (w_job_count),
        .i_jq_full   (w_jq_full),
        .i_done      (w_done),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata)
    );

    osc7_fifo #(.W(JW), .D(JQ_DEPTH)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_job_push),
        .i_din   ({w_job_kind, w_job_count}),
        .i_rd    (w_job_pop),
        .o_dout  (w_jq_dout),
        .o_empty (w_jq_empty),
        .o_full  (w_jq_full),
        .o_count (w_jq_count)
    );

    osc7_ram #(.W(8), .D(BODY_DEPTH)) u_body_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    osc7_back #(.BODY_DEPTH(BODY_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_jq_empty),
        .i_job_kind  (t_kind'(w_jq_dout[JW-1:CW])),
        .i_job_count (w_jq_dout[CW-1:0]),
        .o_job_pop   (w_job_pop),
        .o_done      (w_done),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_oq_count  (w_oq_count)
    );

    osc7_fifo #(.W(RW), .D(OQ_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_push),
        .i_din   (w_res),
        .i_rd    (pop),
        .o_dout  (w_oq_dout),
        .o_empty (empty),
        .o_full  (w_oq_full),
        .o_count (w_oq_count)
    );

    // credit scheme in the back end keeps the result queue from overfilling
    assign w_unused = w_oq_full ^ (^w_jq_count);

    assign o_path_byte     = w_oq_dout.path_byte;
    assign o_run_last      = w_oq_dout.run_last;
    assign o_report_status = w_oq_dout.report_status;
endmodule
